@@ src/assert_macros.svh @@
// Assertion macros for the checker file esiv_checker.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset-qualified
`define ESIV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("esiv assertion failed");

// next-cycle implication, reset-qualified
`define ESIV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("esiv assertion failed");

`endif

@@ src/esiv_pkg.sv @@
// Shared types and constants of the edge-scroll viewport.
// No dependencies; used by esiv_cfg, esiv_axis, the top level and the testbench.
package esiv_pkg;

    typedef struct packed {
        logic [9:0] view;
        logic [9:0] map_size;
        logic [7:0] margin;
        logic [7:0] tile;
    } t_axis_cfg;

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_X    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_Y    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 4'd7;

    localparam logic [9:0] RST_VIEW_WIDTH  = 10'd20;
    localparam logic [9:0] RST_VIEW_HEIGHT = 10'd15;
    localparam logic [9:0] RST_MAP_WIDTH   = 10'd64;
    localparam logic [9:0] RST_MAP_HEIGHT  = 10'd64;
    localparam logic [7:0] RST_MARGIN_X    = 8'd1;
    localparam logic [7:0] RST_MARGIN_Y    = 8'd1;
    localparam logic [7:0] RST_TILE_WIDTH  = 8'd64;
    localparam logic [7:0] RST_TILE_HEIGHT = 8'd32;

    localparam logic signed [6:0] SPEED_LIMIT = 7'sd20;

endpackage

@@ src/edge_scroll_inertia_viewport.sv @@
// Top level of the edge-scroll viewport: input register, two axis units, result register.
// Depends on esiv_pkg, esiv_cfg and esiv_axis.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------------
//  in      | in        | i_in_valid / o_in_stall  | i_cursor_x, i_cursor_y
//  out     | out       | o_out_valid / i_out_stall| o_view_x, o_view_y, o_fine_x, o_fine_y,
//          |           |                          | o_changed
//  cfg     | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One word per cycle in and out while the output is not stalled; a word passes the input register
// and then the axis state registers. The axis state registers double as the result register, so the next word
// sees the state left by the previous one without a gap.
// Reset is synchronous and clears speeds, positions, offsets and valids;
// the registers return to their defaults. Configuration is always ready.
// A stall on the output holds the result and, once the input register fills, stalls the input.
module edge_scroll_inertia_viewport (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [9:0]                          i_cursor_x,
    input  logic [9:0]                          i_cursor_y,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [10:0]                  o_view_x,
    output logic signed [10:0]                  o_view_y,
    output logic [7:0]                          o_fine_x,
    output logic [7:0]                          o_fine_y,
    output logic                                o_changed,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [esiv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [esiv_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    esiv_pkg::t_axis_cfg cfg_x;
    esiv_pkg::t_axis_cfg cfg_y;

    logic       r_in_valid;
    logic [9:0] r_cursor_x;
    logic [9:0] r_cursor_y;
    logic       r_out_valid;
    logic       r_changed;

    logic out_en;
    logic in_stall;
    logic step_en;
    logic moving_x;
    logic moving_y;

    assign out_en   = !r_out_valid || !i_out_stall;
    assign in_stall = r_in_valid && !out_en;
    assign step_en  = out_en && r_in_valid;

    esiv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg_x (cfg_x),
        .o_cfg_y (cfg_y)
    );

    esiv_axis u_axis_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (step_en),
        .i_cursor (r_cursor_x),
        .i_cfg    (cfg_x),
        .o_pos    (o_view_x),
        .o_off    (o_fine_x),
        .o_moving (moving_x)
    );

    esiv_axis u_axis_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (step_en),
        .i_cursor (r_cursor_y),
        .i_cfg    (cfg_y),
        .o_pos    (o_view_y),
        .o_off    (o_fine_y),
        .o_moving (moving_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_changed   <= 1'b0;
        end else begin
            if (!in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_en) begin
                r_out_valid <= r_in_valid;
            end
            if (step_en) begin
                r_changed <= moving_x || moving_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!in_stall && i_in_valid) begin
            r_cursor_x <= i_cursor_x;
            r_cursor_y <= i_cursor_y;
        end
    end

    assign o_in_stall  = in_stall;
    assign o_out_valid = r_out_valid;
    assign o_changed   = r_changed;
    assign o_cfg_ready = 1'b1;

endmodule

@@ src/esiv_cfg.sv @@
// Configuration register file of the edge-scroll viewport.
// Depends on esiv_pkg for register indexes, reset values and t_axis_cfg.
module esiv_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [esiv_pkg::CFG_IDX_W-1:0]      i_index,
    input  logic [esiv_pkg::CFG_DATA_W-1:0]     i_data,
    output esiv_pkg::t_axis_cfg                 o_cfg_x,
    output esiv_pkg::t_axis_cfg                 o_cfg_y
);

    esiv_pkg::t_axis_cfg r_cfg_x;
    esiv_pkg::t_axis_cfg r_cfg_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_x.view     <= esiv_pkg::RST_VIEW_WIDTH;
            r_cfg_x.map_size <= esiv_pkg::RST_MAP_WIDTH;
            r_cfg_x.margin   <= esiv_pkg::RST_MARGIN_X;
            r_cfg_x.tile     <= esiv_pkg::RST_TILE_WIDTH;
            r_cfg_y.view     <= esiv_pkg::RST_VIEW_HEIGHT;
            r_cfg_y.map_size <= esiv_pkg::RST_MAP_HEIGHT;
            r_cfg_y.margin   <= esiv_pkg::RST_MARGIN_Y;
            r_cfg_y.tile     <= esiv_pkg::RST_TILE_HEIGHT;
        end else if (i_we) begin
            case (i_index)
                esiv_pkg::CFG_VIEW_WIDTH:  r_cfg_x.view     <= i_data;
                esiv_pkg::CFG_VIEW_HEIGHT: r_cfg_y.view     <= i_data;
                esiv_pkg::CFG_MAP_WIDTH:   r_cfg_x.map_size <= i_data;
                esiv_pkg::CFG_MAP_HEIGHT:  r_cfg_y.map_size <= i_data;
                esiv_pkg::CFG_MARGIN_X:    r_cfg_x.margin   <= i_data[7:0];
                esiv_pkg::CFG_MARGIN_Y:    r_cfg_y.margin   <= i_data[7:0];
                esiv_pkg::CFG_TILE_WIDTH:  r_cfg_x.tile     <= i_data[7:0];
                esiv_pkg::CFG_TILE_HEIGHT: r_cfg_y.tile     <= i_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_x = r_cfg_x;
    assign o_cfg_y = r_cfg_y;

endmodule

@@ src/esiv_axis.sv @@
// One scroll axis: speed update, offset carry and position clamp, with its state.
// Depends on esiv_pkg for t_axis_cfg and SPEED_LIMIT.
module esiv_axis (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [9:0]              i_cursor,
    input  esiv_pkg::t_axis_cfg     i_cfg,
    output logic signed [10:0]      o_pos,
    output logic [7:0]              o_off,
    output logic                    o_moving
);

    logic signed [6:0]  r_speed;
    logic signed [10:0] r_pos;
    logic [7:0]         r_off;

    logic signed [6:0]  n_speed;
    logic signed [10:0] n_pos;
    logic [7:0]         n_off;

    logic               in_low;
    logic               in_high;
    logic signed [11:0] cur_s;
    logic signed [11:0] hi_lim;
    logic signed [6:0]  s_neg;
    logic signed [6:0]  s_pos;
    logic signed [6:0]  s_bias;
    logic signed [11:0] pos_max;
    logic signed [10:0] sz;
    logic signed [11:0] p0, p1, p2;
    logic signed [10:0] o0, o1, o2;

    always_comb begin
        cur_s   = $signed({2'b00, i_cursor});
        hi_lim  = $signed({2'b00, i_cfg.view}) - $signed({4'b0000, i_cfg.margin});
        in_low  = i_cursor <= {2'b00, i_cfg.margin};
        in_high = cur_s >= hi_lim;

        s_neg  = (r_speed > 7'sd0) ? -r_speed : r_speed;
        s_pos  = (r_speed < 7'sd0) ? -r_speed : r_speed;
        s_bias = r_speed + $signed({6'b000000, r_speed[6]});

        if (in_low) begin
            if (s_neg > -esiv_pkg::SPEED_LIMIT) begin
                n_speed = (s_neg == 7'sd0) ? -7'sd1 : s_neg + s_neg;
            end else begin
                n_speed = s_neg;
            end
        end else if (in_high) begin
            if (s_pos < esiv_pkg::SPEED_LIMIT) begin
                n_speed = (s_pos == 7'sd0) ? 7'sd1 : s_pos + s_pos;
            end else begin
                n_speed = s_pos;
            end
        end else begin
            n_speed = s_bias >>> 1;
        end

        o_moving = n_speed != 7'sd0;

        pos_max = $signed({2'b00, i_cfg.map_size}) - $signed({2'b00, i_cfg.view});
        sz      = $signed({3'b000, i_cfg.tile});
        p0      = $signed({r_pos[10], r_pos});
        o0      = $signed({3'b000, r_off}) + $signed({{4{n_speed[6]}}, n_speed});

        // borrow from the tile position
        p1 = p0;
        o1 = o0;
        if (o0 < 11'sd0) begin
            if (p0 - 12'sd1 < 12'sd0) begin
                p1 = 12'sd0;
                o1 = 11'sd0;
            end else begin
                p1 = p0 - 12'sd1;
                o1 = o0 + sz;
            end
        end

        // carry into the tile position
        p2 = p1;
        o2 = o1;
        if (o1 > sz) begin
            if (p1 + 12'sd1 >= pos_max) begin
                p2 = pos_max - 12'sd1;
                o2 = sz;
            end else begin
                p2 = p1 + 12'sd1;
                o2 = o1 - sz;
            end
        end

        n_pos = o_moving ? p2[10:0] : r_pos;
        n_off = o_moving ? o2[7:0]  : r_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_pos   <= '0;
            r_off   <= '0;
        end else if (i_en) begin
            r_speed <= n_speed;
            r_pos   <= n_pos;
            r_off   <= n_off;
        end
    end

    assign o_pos = r_pos;
    assign o_off = r_off;

endmodule

@@ src/esiv_checker.sv @@
// Port-level checker for the edge-scroll viewport, bound to the top level.
// Depends on assert_macros.svh and edge_scroll_inertia_viewport.
`include "assert_macros.svh"

module esiv_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [10:0]                  o_view_x,
    input  logic signed [10:0]                  o_view_y,
    input  logic [7:0]                          o_fine_x,
    input  logic [7:0]                          o_fine_y,
    input  logic                                o_changed
);

    logic        out_held;
    logic [37:0] view_word;

    assign out_held  = o_out_valid && i_out_stall;
    assign view_word = {o_view_x, o_view_y, o_fine_x, o_fine_y};

    `ESIV_ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, out_held, o_out_valid)

    `ESIV_ASSERT_NEXT(a_out_word_hold, i_clk, i_rst_n, out_held, $stable(view_word) && $stable(o_changed))

    `ESIV_ASSERT_IMPL(a_in_stall_cause, i_clk, i_rst_n, o_in_stall, out_held)

    `ESIV_ASSERT_IMPL(a_idle_no_move, i_clk, i_rst_n, o_out_valid && !o_changed && $past(i_rst_n), $stable(view_word))

endmodule

bind edge_scroll_inertia_viewport esiv_checker u_esiv_checker (.*);

@@ verif/testbench.sv @@
// Self-checking bench for edge_scroll_inertia_viewport: cursor words in, view words out.
// Predicts most frames from its own copy of speed, position, offset and registers.
// Depends on esiv_pkg and the top level of the block.
module testbench;
    import esiv_pkg::*;

    localparam int IDLE_LIMIT = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 4'd15;

    typedef enum int {ZONE_LOW, ZONE_HIGH, ZONE_MID, ZONE_ANY} t_zone;

    typedef struct packed {
        logic signed [6:0]  speed;
        logic signed [10:0] pos;
        logic [7:0]         off;
    } t_axis_state;

    typedef struct packed {
        logic signed [10:0] vx;
        logic signed [10:0] vy;
        logic [7:0]         fx;
        logic [7:0]         fy;
        logic               chg;
    } t_frame;

    typedef struct packed {
        logic [9:0] cx;
        logic [9:0] cy;
        logic       known;
        t_frame     frame;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [9:0]             i_cursor_x;
    logic [9:0]             i_cursor_y;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic signed [10:0]     o_view_x;
    logic signed [10:0]     o_view_y;
    logic [7:0]             o_fine_x;
    logic [7:0]             o_fine_y;
    logic                   o_changed;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    edge_scroll_inertia_viewport dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cursor_x  (i_cursor_x),
        .i_cursor_y  (i_cursor_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_view_x    (o_view_x),
        .o_view_y    (o_view_y),
        .o_fine_x    (o_fine_x),
        .o_fine_y    (o_fine_y),
        .o_changed   (o_changed),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [9:0] cfg_view_w  = RST_VIEW_WIDTH;
    logic [9:0] cfg_view_h  = RST_VIEW_HEIGHT;
    logic [9:0] cfg_map_w   = RST_MAP_WIDTH;
    logic [9:0] cfg_map_h   = RST_MAP_HEIGHT;
    logic [7:0] cfg_margin_x = RST_MARGIN_X;
    logic [7:0] cfg_margin_y = RST_MARGIN_Y;
    logic [7:0] cfg_tile_w  = RST_TILE_WIDTH;
    logic [7:0] cfg_tile_h  = RST_TILE_HEIGHT;

    t_axis_state axis_h = '0;
    t_axis_state axis_v = '0;
    t_frame      pending_views[$];
    int          mismatches = 0;
    int          max_gap = 6;
    int          out_hold = 0;
    int          idle_cycles = 0;

    t_row directed_plan [22] = '{
        '{10'd10,   10'd7,    1'b1, '{11'sd0, 11'sd0, 8'd0,  8'd0,  1'b0}},
        '{10'd0,    10'd0,    1'b1, '{11'sd0, 11'sd0, 8'd0,  8'd0,  1'b1}},
        '{10'd0,    10'd0,    1'b1, '{11'sd0, 11'sd0, 8'd0,  8'd0,  1'b1}},
        '{10'd1023, 10'd1023, 1'b1, '{11'sd0, 11'sd0, 8'd4,  8'd4,  1'b1}},
        '{10'd1023, 10'd1023, 1'b1, '{11'sd0, 11'sd0, 8'd12, 8'd12, 1'b1}},
        '{10'd1023, 10'd1023, 1'b1, '{11'sd0, 11'sd0, 8'd28, 8'd28, 1'b1}},
        '{10'd1023, 10'd1023, 1'b1, '{11'sd0, 11'sd1, 8'd60, 8'd28, 1'b1}},
        '{10'd1023, 10'd1023, 1'b1, '{11'sd1, 11'sd2, 8'd28, 8'd28, 1'b1}},
        '{10'd10,   10'd7,    1'b1, '{11'sd1, 11'sd3, 8'd44, 8'd12, 1'b1}},
        '{10'd10,   10'd7,    1'b0, '0},
        '{10'd19,   10'd14,   1'b0, '0},
        '{10'd18,   10'd13,   1'b0, '0},
        '{10'd1,    10'd1,    1'b0, '0},
        '{10'd2,    10'd2,    1'b0, '0},
        '{10'd2,    10'd2,    1'b0, '0},
        '{10'd2,    10'd2,    1'b0, '0},
        '{10'd2,    10'd2,    1'b0, '0},
        '{10'd2,    10'd2,    1'b0, '0},
        '{10'd1,    10'd14,   1'b0, '0},
        '{10'd1023, 10'd0,    1'b0, '0},
        '{10'd682,  10'd341,  1'b0, '0},
        '{10'd341,  10'd682,  1'b0, '0}
    };

    function automatic t_axis_state scroll_axis(t_axis_state st, int cur, int view,
                                                int margin, int tile, int map_size);
        t_axis_state nxt;
        int s, p, o, lim;
        s = st.speed;
        p = st.pos;
        o = st.off;
        if (cur <= margin) begin
            if (s > 0) s = -s;
            if (s > -int'(SPEED_LIMIT)) s = (s != 0) ? 2 * s : -1;
        end else if (cur >= view - margin) begin
            if (s < 0) s = -s;
            if (s < int'(SPEED_LIMIT)) s = (s != 0) ? 2 * s : 1;
        end else begin
            s = s / 2;
        end
        if (s != 0) begin
            lim = map_size - view;
            o = o + s;
            if (o < 0) begin
                p = p - 1;
                if (p < 0) begin
                    p = 0;
                    o = 0;
                end else begin
                    o = o + tile;
                end
            end
            if (o > tile) begin
                p = p + 1;
                if (p >= lim) begin
                    p = lim - 1;
                    o = tile;
                end else begin
                    o = o - tile;
                end
            end
        end
        nxt.speed = s[6:0];
        nxt.pos   = p[10:0];
        nxt.off   = o[7:0];
        return nxt;
    endfunction

    function automatic int field_mismatch(string name, logic signed [31:0] want,
                                          logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    function automatic logic [9:0] pick_cursor(t_zone zone, int view, int margin);
        int lo, hi;
        case (zone)
            ZONE_LOW: begin
                lo = 0;
                hi = margin;
            end
            ZONE_HIGH: begin
                lo = (view > margin) ? view - margin : 0;
                hi = (view + 3 > 1023) ? 1023 : view + 3;
            end
            ZONE_MID: begin
                lo = margin + 1;
                hi = view - margin - 1;
            end
            default: begin
                lo = 0;
                hi = 1023;
            end
        endcase
        if (lo > hi) begin
            lo = 0;
            hi = 1023;
        end
        return 10'($urandom_range(hi, lo));
    endfunction

    task automatic send_cursor(input logic [9:0] cx, input logic [9:0] cy,
                               input logic known, input t_frame typed);
        int gap;
        t_frame predicted;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cursor_x <= cx;
        i_cursor_y <= cy;
        do @(posedge i_clk); while (o_in_stall);
        axis_h = scroll_axis(axis_h, cx, cfg_view_w, cfg_margin_x, cfg_tile_w, cfg_map_w);
        axis_v = scroll_axis(axis_v, cy, cfg_view_h, cfg_margin_y, cfg_tile_h, cfg_map_h);
        predicted.vx  = axis_h.pos;
        predicted.vy  = axis_v.pos;
        predicted.fx  = axis_h.off;
        predicted.fy  = axis_v.off;
        predicted.chg = (axis_h.speed != 0) || (axis_v.speed != 0);
        pending_views.push_back(known ? typed : predicted);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_VIEW_WIDTH:  cfg_view_w   = data;
            CFG_VIEW_HEIGHT: cfg_view_h   = data;
            CFG_MAP_WIDTH:   cfg_map_w    = data;
            CFG_MAP_HEIGHT:  cfg_map_h    = data;
            CFG_MARGIN_X:    cfg_margin_x = data[7:0];
            CFG_MARGIN_Y:    cfg_margin_y = data[7:0];
            CFG_TILE_WIDTH:  cfg_tile_w   = data[7:0];
            CFG_TILE_HEIGHT: cfg_tile_h   = data[7:0];
            default: ;
        endcase
    endtask

    task automatic program_view(input int vw, input int vh, input int mw, input int mh,
                                input int mx, input int my, input int tw, input int th);
        write_reg(CFG_VIEW_WIDTH,  vw[9:0]);
        write_reg(CFG_VIEW_HEIGHT, vh[9:0]);
        write_reg(CFG_MAP_WIDTH,   mw[9:0]);
        write_reg(CFG_MAP_HEIGHT,  mh[9:0]);
        write_reg(CFG_MARGIN_X,    mx[9:0]);
        write_reg(CFG_MARGIN_Y,    my[9:0]);
        write_reg(CFG_TILE_WIDTH,  tw[9:0]);
        write_reg(CFG_TILE_HEIGHT, th[9:0]);
    endtask

    // drop valid, wait out every pending frame, then hold the input idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n_items);
        int left, seg;
        t_zone zx, zy;
        logic [9:0] cx, cy;
        i_cfg_valid <= 1'b0;
        left = n_items;
        while (left > 0) begin
            seg = $urandom_range(1, 12);
            zx = t_zone'($urandom_range(0, 3));
            zy = t_zone'($urandom_range(0, 3));
            while (seg > 0 && left > 0) begin
                cx = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                                 : pick_cursor(zx, cfg_view_w, cfg_margin_x);
                cy = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                                 : pick_cursor(zy, cfg_view_h, cfg_margin_y);
                send_cursor(cx, cy, 1'b0, '0);
                seg--;
                left--;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_views.size() == 0) begin
                $error("view word with no frame pending");
                mismatches++;
            end else begin
                want = pending_views.pop_front();
                mismatches += field_mismatch("view_x", want.vx, o_view_x);
                mismatches += field_mismatch("view_y", want.vy, o_view_y);
                mismatches += field_mismatch("fine_x", want.fx, o_fine_x);
                mismatches += field_mismatch("fine_y", want.fy, o_fine_y);
                mismatches += field_mismatch("changed", want.chg, o_changed);
            end
            out_hold = $urandom_range(0, max_gap);
        end
        if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int vw, vh, mw, mh;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_cursor_x  = '0;
        i_cursor_y  = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 22; i++) begin
            send_cursor(directed_plan[i].cx, directed_plan[i].cy,
                        directed_plan[i].known, directed_plan[i].frame);
        end

        settle();
        program_view(1, 1, 1, 1, 0, 0, 32, 32);
        run_phase(40);

        settle();
        program_view(1023, 1023, 1023, 1023, 255, 255, 255, 255);
        max_gap = 0;
        run_phase(40);

        // margin wider than the view on x, tile shrunk under the held offset
        settle();
        max_gap = 6;
        program_view(10, 12, 300, 200, 200, 200, 32, 40);
        write_reg(CFG_IDX_SPARE_LO, 10'h155);
        write_reg(CFG_MARGIN_Y, 10'h305);
        write_reg(CFG_TILE_HEIGHT, 10'h340);
        write_reg(CFG_IDX_SPARE_HI, 10'h3FF);
        run_phase(40);

        for (int k = 0; k < 9; k++) begin
            settle();
            if (k % 4 == 3) begin
                program_view($urandom_range(1, 1023), $urandom_range(1, 1023),
                             $urandom_range(1, 1023), $urandom_range(1, 1023),
                             $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(32, 255), $urandom_range(32, 255));
            end else begin
                vw = $urandom_range(4, 80);
                vh = $urandom_range(4, 80);
                mw = vw + $urandom_range(2, 30);
                mh = vh + $urandom_range(2, 30);
                program_view(vw, vh, mw, mh, $urandom_range(0, vw / 3),
                             $urandom_range(0, vh / 3),
                             $urandom_range(32, 255), $urandom_range(32, 255));
            end
            max_gap = (k % 3 == 2) ? 0 : 6;
            run_phase(65);
        end

        settle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
